// ===== sv/hpa_pkg.sv =====
`timescale 1ns / 1ps

package hpa_pkg;

  // default pool size and queue depths
  localparam int POOL_SIZE_DEF = 256;
  localparam int CMD_DEPTH     = 2;
  localparam int OUT_DEPTH     = 4;

  // request opcodes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_TRY     = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE      = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // request word
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] handle_in;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [7:0] handle_out;
    logic [1:0] status;
  } rsp_t;

  // request class as decided by the front end
  typedef enum logic [1:0] {
    K_ALLOC,
    K_TRY,
    K_RELEASE,
    K_BAD
  } kind_t;

  // classified request handed to the back end
  typedef struct packed {
    kind_t      kind;
    logic       in_range;
    logic [7:0] handle;
  } cls_t;

endpackage

// ===== sv/handle_pool_allocator_unit.sv =====
`timescale 1ns / 1ps

// Handle pool allocator: hands out object handles from a pool of POOL_SIZE,
// reusing released handles oldest first before issuing fresh ones.
// Request side: a queue write port. A word (opcode, handle_in) is taken on a
// rising edge with push high and full low.
// Result side: a queue read port. While empty is low the oldest result word
// (handle_out, status) is on rsp; it is taken on an edge with pop high.
// Every request gives exactly one result, in request order.
// Path: a fresh issue or an error passes the request queue, the registered
// result and the result queue; a reuse or a release also waits on one
// registered read of the released list or busy flag memory.
// Throughput: one request per cycle for fresh issues and errors while the
// result queue has room; after a reuse or release the next waits on that read.
// If pop stays low the result queue fills, the back end holds, the request
// queue fills and full rises; nothing is dropped.
// Reset clears the list, the issued count and all queues at once; the busy
// flags need no clearing since only issued handles are ever looked up.
module handle_pool_allocator_unit #(
  parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  hpa_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output hpa_pkg::rsp_t rsp
);

  import hpa_pkg::*;

  localparam int OLW = $clog2(OUT_DEPTH + 1);

  cls_t           cls;
  logic           cls_avail;
  logic           cls_pop;
  logic [OLW-1:0] out_level;
  logic           out_full;
  logic           res_vld;
  rsp_t           res;

  // accept and classify
  hpa_front #(
    .POOL_SIZE (POOL_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .cls_avail (cls_avail),
    .cls       (cls),
    .cls_pop   (cls_pop)
  );

  // execute against the list and busy flags
  hpa_back #(
    .POOL_SIZE (POOL_SIZE),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_avail (cls_avail),
    .cls       (cls),
    .cls_pop   (cls_pop),
    .out_level (out_level),
    .res_vld   (res_vld),
    .res       (res)
  );

  // result queue
  hpa_fifo #(
    .WIDTH ($bits(rsp_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_vld),
    .wdata (res),
    .pop   (pop),
    .rdata (rsp),
    .empty (empty),
    .full  (out_full),
    .level (out_level)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> !out_full)
    else $error("result word pushed into a full queue");

  a_ok_release_zero: assert property (@(posedge clk) disable iff (rst)
    (res_vld && (res.status != ST_OK)) |-> (res.handle_out == 8'd0))
    else $error("error result carries a nonzero handle");

  a_pop_needs_result: assert property (@(posedge clk) disable iff (rst)
    cls_pop |-> cls_avail)
    else $error("back end took a command from an empty queue");

endmodule

// ===== sv/hpa_ram.sv =====
`timescale 1ns / 1ps

module hpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/hpa_fifo.sv =====
`timescale 1ns / 1ps

module hpa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [LW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == LW'(DEPTH));
  assign level   = count;
  assign rdata   = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + LW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - LW'(1);
      end
    end
  end

endmodule

// ===== sv/hpa_front.sv =====
`timescale 1ns / 1ps

module hpa_front #(
  parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  hpa_pkg::cmd_t cmd,
  output logic          cls_avail,
  output hpa_pkg::cls_t cls,
  input  logic          cls_pop
);

  import hpa_pkg::*;

  localparam int QLW = $clog2(CMD_DEPTH + 1);

  cls_t           cls_in;
  logic           q_empty;
  logic [QLW-1:0] q_level;

  // decode the opcode and range check the handle
  always_comb begin
    cls_in.handle   = cmd.handle_in;
    cls_in.in_range = (32'(cmd.handle_in) < 32'(POOL_SIZE));
    unique case (cmd.opcode)
      OP_ALLOC:   cls_in.kind = K_ALLOC;
      OP_TRY:     cls_in.kind = K_TRY;
      OP_RELEASE: cls_in.kind = K_RELEASE;
      default:    cls_in.kind = K_BAD;
    endcase
  end

  // short queue toward the back end
  hpa_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_in),
    .pop   (cls_pop),
    .rdata (cls),
    .empty (q_empty),
    .full  (full),
    .level (q_level)
  );

  assign cls_avail = !q_empty;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= QLW'(CMD_DEPTH))
    else $error("command queue level out of range");

  a_avail_level: assert property (@(posedge clk) disable iff (rst)
    cls_avail == (q_level != '0))
    else $error("command available flag disagrees with queue level");

  a_full_level: assert property (@(posedge clk) disable iff (rst)
    full == (q_level == QLW'(CMD_DEPTH)))
    else $error("full flag disagrees with queue level");

endmodule

// ===== sv/hpa_back.sv =====
`timescale 1ns / 1ps

module hpa_back #(
  parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF,
  parameter int OUT_DEPTH = hpa_pkg::OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cls_avail,
  input  hpa_pkg::cls_t                  cls,
  output logic                           cls_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
  output logic                           res_vld,
  output hpa_pkg::rsp_t                  res
);

  import hpa_pkg::*;

  localparam int HW  = (POOL_SIZE > 2) ? $clog2(POOL_SIZE) : 1;
  localparam int CW  = $clog2(POOL_SIZE + 1);
  localparam int XW  = (HW > 8) ? HW : 8;
  localparam int OLW = $clog2(OUT_DEPTH + 1) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_REL
  } state_t;

  state_t        state, state_next;
  logic [HW-1:0] list_head, list_head_next;
  logic [HW-1:0] list_tail, list_tail_next;
  logic [CW-1:0] list_count, list_count_next;
  logic [CW-1:0] issued_count, issued_count_next;
  logic [HW-1:0] rel_addr, rel_addr_next;
  logic          rel_known, rel_known_next;

  logic          start;
  logic          emit_vld;
  rsp_t          emit;

  logic          list_we, list_re;
  logic [HW-1:0] list_waddr, list_raddr, list_wdata, list_rdata;
  logic          busy_we, busy_re, busy_wdata, busy_rdata;
  logic [HW-1:0] busy_waddr, busy_raddr;
  logic [HW-1:0] cls_addr;

  // room for one more result counting the one in flight
  assign start    = (state == S_IDLE) && cls_avail &&
                    ((OLW'(out_level) + OLW'(res_vld)) < OLW'(OUT_DEPTH));
  assign cls_pop  = start;
  assign cls_addr = HW'(XW'(cls.handle));

  // released handle ring
  hpa_ram #(
    .WIDTH (HW),
    .DEPTH (POOL_SIZE)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  // busy flag per handle, only meaningful below issued_count
  hpa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_SIZE)
  ) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .re    (busy_re),
    .raddr (busy_raddr),
    .rdata (busy_rdata)
  );

  // command execution
  always_comb begin
    state_next        = state;
    list_head_next    = list_head;
    list_tail_next    = list_tail;
    list_count_next   = list_count;
    issued_count_next = issued_count;
    rel_addr_next     = rel_addr;
    rel_known_next    = rel_known;
    emit_vld          = 1'b0;
    emit.handle_out   = '0;
    emit.status       = ST_OK;
    list_we           = 1'b0;
    list_waddr        = list_tail;
    list_wdata        = rel_addr;
    list_re           = 1'b0;
    list_raddr        = list_head;
    busy_we           = 1'b0;
    busy_waddr        = rel_addr;
    busy_wdata        = 1'b0;
    busy_re           = 1'b0;
    busy_raddr        = cls_addr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (cls.kind) inside
            K_ALLOC, K_TRY: begin
              if (list_count != '0) begin
                // reuse: read the oldest released handle
                list_re        = 1'b1;
                list_head_next = (list_head == HW'(POOL_SIZE - 1)) ?
                                 '0 : list_head + HW'(1);
                list_count_next = list_count - CW'(1);
                state_next     = S_POP;
              end else if (cls.kind == K_TRY) begin
                emit_vld    = 1'b1;
                emit.status = ST_NONE;
              end else if (32'(issued_count) >= 32'(POOL_SIZE)) begin
                emit_vld    = 1'b1;
                emit.status = ST_EXHAUSTED;
              end else begin
                // fresh handle
                busy_we           = 1'b1;
                busy_waddr        = issued_count[HW-1:0];
                busy_wdata        = 1'b1;
                issued_count_next = issued_count + CW'(1);
                emit_vld          = 1'b1;
                emit.handle_out   = 8'(XW'(issued_count[HW-1:0]));
              end
            end
            K_RELEASE: begin
              if (!cls.in_range || (32'(list_count) >= 32'(POOL_SIZE))) begin
                emit_vld    = 1'b1;
                emit.status = ST_INVALID;
              end else begin
                busy_re        = 1'b1;
                rel_addr_next  = cls_addr;
                rel_known_next = (32'(cls.handle) < 32'(issued_count));
                state_next     = S_REL;
              end
            end
            default: begin
              emit_vld    = 1'b1;
              emit.status = ST_INVALID;
            end
          endcase
        end
      end
      S_POP: begin
        busy_we         = 1'b1;
        busy_waddr      = list_rdata;
        busy_wdata      = 1'b1;
        emit_vld        = 1'b1;
        emit.handle_out = 8'(XW'(list_rdata));
        state_next      = S_IDLE;
      end
      S_REL: begin
        emit_vld = 1'b1;
        if (rel_known && busy_rdata) begin
          busy_we         = 1'b1;
          list_we         = 1'b1;
          list_tail_next  = (list_tail == HW'(POOL_SIZE - 1)) ?
                            '0 : list_tail + HW'(1);
          list_count_next = list_count + CW'(1);
        end else begin
          emit.status = ST_INVALID;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      list_head    <= '0;
      list_tail    <= '0;
      list_count   <= '0;
      issued_count <= '0;
      res_vld      <= 1'b0;
    end else begin
      state        <= state_next;
      list_head    <= list_head_next;
      list_tail    <= list_tail_next;
      list_count   <= list_count_next;
      issued_count <= issued_count_next;
      res_vld      <= emit_vld;
    end
    rel_addr  <= rel_addr_next;
    rel_known <= rel_known_next;
    res       <= emit;
  end

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    32'(list_count) <= 32'(POOL_SIZE))
    else $error("released list count above pool size");

  a_issued_bound: assert property (@(posedge clk) disable iff (rst)
    32'(issued_count) <= 32'(POOL_SIZE))
    else $error("issued count above pool size");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (res_vld && (res.status == ST_OK)))
    else $error("reuse did not give an ok result");

  a_wait_no_start: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cls_pop)
    else $error("command taken while another is in progress");

endmodule

// ===== tb/handle_pool_allocator_unit_chk.sv =====
`timescale 1ns / 1ps

module handle_pool_allocator_unit_chk (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          full,
  input  hpa_pkg::cmd_t cmd,
  input  logic          empty,
  input  logic          pop,
  input  hpa_pkg::rsp_t rsp,
  output int            fails,
  output int            pending,
  output int            checked,
  output int            exhausted_seen,
  output int            none_seen,
  output int            invalid_seen
);

  import hpa_pkg::*;

  localparam int POOL = POOL_SIZE_DEF;

  // shadow pool state
  logic [7:0] free_ring [POOL];
  logic       in_use [POOL];
  int         ring_rd;
  int         ring_wr;
  int         ring_cnt;
  int         fresh_next;

  // result words owed by the block, oldest first
  rsp_t owed_rsp [$];
  rsp_t want;

  // work out the result word of one request and update the shadow pool
  task automatic apply_pool_op(input cmd_t c);
    rsp_t r;
    int   h;
    r = '{handle_out: 8'd0, status: ST_OK};
    case (c.opcode) inside
      OP_ALLOC, OP_TRY: begin
        if (ring_cnt > 0) begin
          h = int'(free_ring[ring_rd]);
          ring_rd = (ring_rd + 1) % POOL;
          ring_cnt--;
          in_use[h] = 1'b1;
          r.handle_out = h[7:0];
        end else if (c.opcode == OP_TRY) begin
          r.status = ST_NONE;
        end else if (fresh_next >= POOL) begin
          r.status = ST_EXHAUSTED;
        end else begin
          h = fresh_next;
          fresh_next++;
          in_use[h] = 1'b1;
          r.handle_out = h[7:0];
        end
      end
      OP_RELEASE: begin
        if (int'(c.handle_in) >= POOL || !in_use[c.handle_in] || ring_cnt >= POOL) begin
          r.status = ST_INVALID;
        end else begin
          in_use[c.handle_in] = 1'b0;
          free_ring[ring_wr] = c.handle_in;
          ring_wr = (ring_wr + 1) % POOL;
          ring_cnt++;
        end
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    owed_rsp.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ring_rd = 0;
      ring_wr = 0;
      ring_cnt = 0;
      fresh_next = 0;
      foreach (in_use[i]) in_use[i] = 1'b0;
      owed_rsp.delete();
    end else begin
      // request word taken
      if (push && !full) begin
        apply_pool_op(cmd);
      end
      // result word taken
      if (pop && !empty) begin
        if (owed_rsp.size() == 0) begin
          $error("result word with nothing owed: handle_out %0d status %0d",
                 rsp.handle_out, rsp.status);
          fails++;
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.handle_out !== want.handle_out) begin
            $error("handle_out mismatch: expected %0d, got %0d",
                   want.handle_out, rsp.handle_out);
            fails++;
          end
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
            fails++;
          end
          checked++;
          case (want.status)
            ST_EXHAUSTED: exhausted_seen++;
            ST_NONE:      none_seen++;
            ST_INVALID:   invalid_seen++;
            default:      ;
          endcase
        end
      end
    end
    pending = owed_rsp.size();
  end

endmodule

// ===== tb/handle_pool_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module handle_pool_allocator_unit_tb;
  import hpa_pkg::*;

  // opcode with no meaning, answered as invalid
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push;
  logic full;
  cmd_t cmd;
  logic empty;
  logic pop;
  rsp_t rsp;

  int fails;
  int pending;
  int checked;
  int exhausted_seen;
  int none_seen;
  int invalid_seen;

  int sent_cnt = 0;
  int held_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  handle_pool_allocator_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .cmd   (cmd),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

  handle_pool_allocator_unit_chk u_chk (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .cmd            (cmd),
    .empty          (empty),
    .pop            (pop),
    .rsp            (rsp),
    .fails          (fails),
    .pending        (pending),
    .checked        (checked),
    .exhausted_seen (exhausted_seen),
    .none_seen      (none_seen),
    .invalid_seen   (invalid_seen)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random opcode by percentage weights, remainder goes to the unused code
  function automatic logic [1:0] pick_op(input int alloc_pct, input int try_pct,
                                         input int rel_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) return OP_ALLOC;
    if (r < alloc_pct + try_pct) return OP_TRY;
    if (r < alloc_pct + try_pct + rel_pct) return OP_RELEASE;
    return OP_UNUSED;
  endfunction

  // offer one request word and wait until it is taken
  task automatic send_word(input logic [1:0] op, input logic [7:0] h);
    int gap;
    if (sent_cnt % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    cmd <= '{opcode: op, handle_in: h};
    do @(posedge clk); while (full);
    sent_cnt++;
    @(negedge clk);
  endtask

  // release every handle once, in shuffled order
  task automatic release_sweep();
    int order [256];
    int j;
    int t;
    foreach (order[i]) order[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) send_word(OP_RELEASE, order[i][7:0]);
  endtask

  // request side
  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cmd = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: nothing released, never issued, double release, unused opcode
    send_word(OP_TRY, 8'hFF);
    send_word(OP_RELEASE, 8'h00);
    send_word(OP_ALLOC, 8'h00);
    send_word(OP_ALLOC, 8'hFF);
    send_word(OP_ALLOC, 8'h55);
    send_word(OP_RELEASE, 8'h01);
    send_word(OP_RELEASE, 8'h01);
    send_word(OP_RELEASE, 8'hFF);
    send_word(OP_UNUSED, 8'h00);
    send_word(OP_UNUSED, 8'hFF);
    send_word(OP_RELEASE, 8'h02);
    send_word(OP_TRY, 8'h00);
    send_word(OP_ALLOC, 8'hAA);
    send_word(OP_TRY, 8'h00);
    send_word(OP_ALLOC, 8'hAA);
    send_word(OP_RELEASE, 8'h00);
    send_word(OP_RELEASE, 8'h03);
    send_word(OP_TRY, 8'h0F);
    send_word(OP_TRY, 8'hF0);
    send_word(OP_TRY, 8'h00);

    // allocation heavy until the pool runs out and reports exhaustion
    repeat (360) send_word(pick_op(88, 4, 6), 8'($urandom_range(0, 255)));

    // release everything so the released list fills up, then drain it
    release_sweep();
    repeat (260) send_word(pick_op(50, 50, 0), 8'($urandom_range(0, 255)));

    // mixed traffic
    repeat (700) send_word(pick_op(40, 20, 37), 8'($urandom_range(0, 255)));

    // final sweep leaves a deep released list
    release_sweep();
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d results: %0d exhausted, %0d none, %0d invalid",
             sent_cnt, checked, exhausted_seen, none_seen, invalid_seen);
    $display("result side held off for %0d cycles with requests still offered",
             held_cycles);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side with random stalls and one long hold-off
  initial begin
    int stall;
    int pops;
    pops = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (held_cycles == 0 && sent_cnt >= 120) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          held_cycles++;
        end
      end
      if (pops % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : pick_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
      pops++;
    end
  end

  // run limit
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
